// ----- rtl/core/usb_transfer_packetizer_macros.svh -----
// ----------------------------------------------------------------------------
// usb transfer packetizer assertion macros
// shared concurrent assertion forms, clocked on clk_i, quiet during reset
// ----------------------------------------------------------------------------
`ifndef USB_TRANSFER_PACKETIZER_MACROS_SVH
`define USB_TRANSFER_PACKETIZER_MACROS_SVH

// same-cycle implication
`define USB_TP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define USB_TP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/usb_tp_pkg.sv -----
// ----------------------------------------------------------------------------
// usb_tp_pkg
// types and constants shared by the usb transfer packetizer modules
// ----------------------------------------------------------------------------
package usb_tp_pkg;

  typedef enum logic [1:0] {
    CMD_CONTROL = 2'd0,
    CMD_BULK    = 2'd1,
    CMD_INTR    = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    PID_SETUP = 2'd0,
    PID_IN    = 2'd1,
    PID_OUT   = 2'd2
  } pid_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SETUP,
    PH_DATA,
    PH_STATUS
  } phase_e;

  localparam logic [9:0] MPS_DEF_SHORT = 10'd8;
  localparam logic [9:0] MPS_DEF_BULK  = 10'd64;
  localparam logic [9:0] SETUP_LEN     = 10'd8;

  // depth of the job queue between front and back
  localparam int JOB_DEPTH = 2;

  typedef struct packed {
    cmd_e        kind;
    pid_e        data_pid;
    logic [15:0] length;
    logic [9:0]  mps;
    logic        toggle;
    logic [3:0]  endpoint;
    logic [6:0]  address;
    logic        low_speed;
  } job_t;

  typedef struct packed {
    pid_e        pid;
    logic [9:0]  length;
    logic        toggle;
    logic [3:0]  endpoint;
    logic [6:0]  address;
    logic        low_speed;
    logic        ioc;
    logic        spd;
    logic [15:0] offset;
    logic        last;
    logic        next_toggle;
    logic        truncated;
  } desc_t;

  // queue side of the front/back split
  typedef struct packed {
    logic valid;
    job_t job;
  } job_beat_t;

endpackage

// ----- rtl/core/usb_tp_front.sv -----
// ----------------------------------------------------------------------------
// usb_tp_front
// accepts transfer requests, resolves defaults and pushes jobs to the queue
// ----------------------------------------------------------------------------
module usb_tp_front (
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            command_i,
  input  logic [15:0]           transfer_length_i,
  input  logic [9:0]            max_packet_i,
  input  logic                  direction_in_i,
  input  logic                  start_toggle_i,
  input  logic [6:0]            device_address_i,
  input  logic [3:0]            endpoint_number_i,
  input  logic                  low_speed_i,
  input  logic                  queue_full_i,
  output usb_tp_pkg::job_beat_t push_o
);
  import usb_tp_pkg::*;

  logic [9:0] mps;
  logic       keep;
  logic       clamp;

  assign in_ready_o = !queue_full_i;

  always_comb begin
    mps   = max_packet_i;
    keep  = 1'b0;
    clamp = transfer_length_i > {6'b0, mps};
    push_o.job.kind      = cmd_e'(command_i);
    push_o.job.data_pid  = direction_in_i ? PID_IN : PID_OUT;
    push_o.job.length    = transfer_length_i;
    push_o.job.toggle    = start_toggle_i;
    push_o.job.endpoint  = endpoint_number_i;
    push_o.job.address   = device_address_i;
    push_o.job.low_speed = low_speed_i;
    case (cmd_e'(command_i))
      CMD_CONTROL: begin
        if (max_packet_i == 10'd0) mps = MPS_DEF_SHORT;
        keep = 1'b1;
      end
      CMD_BULK: begin
        if (max_packet_i == 10'd0) mps = MPS_DEF_BULK;
        // empty bulk transfer makes no descriptors
        keep = transfer_length_i != 16'd0;
      end
      CMD_INTR: begin
        if (max_packet_i == 10'd0) mps = MPS_DEF_SHORT;
        clamp = transfer_length_i > {6'b0, mps};
        push_o.job.data_pid = PID_IN;
        if (clamp) push_o.job.length = {6'b0, mps};
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
    push_o.job.mps = mps;
    push_o.valid   = in_valid_i && in_ready_o && keep;
  end

endmodule

// ----- rtl/core/usb_tp_fifo.sv -----
// ----------------------------------------------------------------------------
// usb_tp_fifo
// short job queue decoupling the request front from the descriptor back
// ----------------------------------------------------------------------------
module usb_tp_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  usb_tp_pkg::job_beat_t push_i,
  output logic                  full_o,
  output usb_tp_pkg::job_beat_t head_o,
  input  logic                  pop_i
);
  import usb_tp_pkg::*;

  localparam int PtrW = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
  localparam int CntW = $clog2(JOB_DEPTH + 1);

  job_t            mem_q [JOB_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o       = cnt_q == CntW'(JOB_DEPTH);
  assign head_o.valid = cnt_q != '0;
  assign head_o.job   = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(JOB_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(JOB_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_i.job;
  end

endmodule

// ----- rtl/core/usb_tp_back.sv -----
// ----------------------------------------------------------------------------
// usb_tp_back
// walks one job at a time and emits its descriptors into the output register
// ----------------------------------------------------------------------------
module usb_tp_back #(
  parameter int MAX_RESULTS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  usb_tp_pkg::job_beat_t head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output usb_tp_pkg::desc_t     desc_o
);
  import usb_tp_pkg::*;

  localparam int CntW = $clog2(MAX_RESULTS);

  phase_e          phase_q, phase_d, phase_nxt;
  job_t            job_q;
  logic [15:0]     rem_q, off_q;
  logic            tog_q;
  logic [CntW-1:0] cnt_q;
  logic            out_valid_q;
  desc_t           desc_q, desc_d;

  logic       slot_free, step, load;
  logic       fin, more, at_limit;
  logic [9:0] chunk;

  assign slot_free = !out_valid_q || out_ready_i;
  assign step      = (phase_q != PH_IDLE) && slot_free;
  assign load      = (phase_q == PH_IDLE) && head_i.valid;
  assign pop_o     = load;
  assign at_limit  = cnt_q == CntW'(MAX_RESULTS - 1);

  always_comb begin
    fin   = !(rem_q > {6'b0, job_q.mps});
    chunk = fin ? rem_q[9:0] : job_q.mps;
    more      = 1'b0;
    phase_nxt = PH_IDLE;
    desc_d.pid       = PID_SETUP;
    desc_d.length    = '0;
    desc_d.toggle    = 1'b0;
    desc_d.endpoint  = '0;
    desc_d.address   = job_q.address;
    desc_d.low_speed = job_q.low_speed;
    desc_d.ioc       = 1'b0;
    desc_d.spd       = 1'b0;
    desc_d.offset    = '0;
    case (phase_q)
      PH_SETUP: begin
        desc_d.length = SETUP_LEN;
        more          = 1'b1;
        phase_nxt     = (rem_q != '0) ? PH_DATA : PH_STATUS;
      end
      PH_DATA: begin
        desc_d.pid      = job_q.data_pid;
        desc_d.length   = chunk;
        desc_d.toggle   = tog_q;
        desc_d.endpoint = (job_q.kind == CMD_CONTROL) ? 4'd0 : job_q.endpoint;
        desc_d.ioc      = (job_q.kind != CMD_CONTROL) && fin;
        desc_d.spd      = job_q.kind == CMD_INTR;
        desc_d.offset   = off_q;
        more            = !fin || (job_q.kind == CMD_CONTROL);
        phase_nxt       = fin ? PH_STATUS : PH_DATA;
      end
      PH_STATUS: begin
        // status stage runs opposite to the data stage
        desc_d.pid    = (job_q.data_pid == PID_IN) ? PID_OUT : PID_IN;
        desc_d.toggle = 1'b1;
        desc_d.ioc    = 1'b1;
      end
      default: begin
        more = 1'b0;
      end
    endcase
    desc_d.last        = !more || at_limit;
    desc_d.truncated   = more && at_limit;
    desc_d.next_toggle = desc_d.last && !desc_d.toggle;

    phase_d = phase_q;
    if (load) begin
      phase_d = (head_i.job.kind == CMD_CONTROL) ? PH_SETUP : PH_DATA;
    end else if (step) begin
      phase_d = desc_d.last ? PH_IDLE : phase_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      phase_q <= phase_d;
      if (step) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (load) cnt_q <= '0;
      else if (step && !desc_d.last) cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= head_i.job;
      rem_q <= head_i.job.length;
      off_q <= '0;
      tog_q <= (head_i.job.kind == CMD_CONTROL) ? 1'b1 : head_i.job.toggle;
    end else if (step && phase_q == PH_DATA) begin
      rem_q <= rem_q - {6'b0, chunk};
      off_q <= off_q + {6'b0, chunk};
      tog_q <= !tog_q;
    end
    if (step) desc_q <= desc_d;
  end

  assign out_valid_o = out_valid_q;
  assign desc_o      = desc_q;

endmodule

// ----- rtl/core/usb_transfer_packetizer.sv -----
// ----------------------------------------------------------------------------
// usb_transfer_packetizer
// expands control, bulk and interrupt transfer requests into transactions
// ----------------------------------------------------------------------------
// usage
//   input channel: one beat per transfer request (in_valid_i / in_ready_o)
//   output channel: one beat per transaction descriptor (out_valid_o /
//   out_ready_i); last_o marks the final descriptor of a request's run
//   a control request gives setup, data chunks and a status beat; bulk gives
//   max-packet chunks; interrupt gives one clamped in beat
//   runs longer than MAX_RESULTS beats are cut, truncated_o set on the last
//   bulk with zero length and the unused command code give no beats
// timing
//   the front decodes a request combinationally into a two-deep job queue
//   the back loads a job, then emits one descriptor per cycle while the
//   output register is free (out_valid_o low or out_ready_i high)
//   the single descriptor sequencer loads a new job only from idle, after the
//   last descriptor of the one before; the front keeps taking requests while
//   the queue has room
// reset and stall
//   reset empties the queue and the output register, the sequencer goes idle
//   when out_ready_i is low the output register holds its beat, the
//   sequencer waits, and the queue fills until in_ready_o drops
// ----------------------------------------------------------------------------
`include "usb_transfer_packetizer_macros.svh"

module usb_transfer_packetizer #(
  parameter int MAX_RESULTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] transfer_length_i,
  input  logic [9:0]  max_packet_i,
  input  logic        direction_in_i,
  input  logic        start_toggle_i,
  input  logic [6:0]  device_address_i,
  input  logic [3:0]  endpoint_number_i,
  input  logic        low_speed_i,
  // descriptor channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  packet_pid_o,
  output logic [9:0]  packet_length_o,
  output logic        data_toggle_o,
  output logic [3:0]  target_endpoint_o,
  output logic [6:0]  target_address_o,
  output logic        low_speed_flag_o,
  output logic        interrupt_on_complete_o,
  output logic        short_packet_detect_o,
  output logic [15:0] byte_offset_o,
  output logic        last_o,
  output logic        next_toggle_o,
  output logic        truncated_o
);
  import usb_tp_pkg::*;

  job_beat_t push;    // front to queue
  job_beat_t head;    // queue to back
  logic      queue_full;
  logic      pop;
  desc_t     desc;

  // request decode and default resolution
  usb_tp_front u_front (
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .command_i         (command_i),
    .transfer_length_i (transfer_length_i),
    .max_packet_i      (max_packet_i),
    .direction_in_i    (direction_in_i),
    .start_toggle_i    (start_toggle_i),
    .device_address_i  (device_address_i),
    .endpoint_number_i (endpoint_number_i),
    .low_speed_i       (low_speed_i),
    .queue_full_i      (queue_full),
    .push_o            (push)
  );

  // job queue lets front and back stall independently
  usb_tp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (queue_full),
    .head_o (head),
    .pop_i  (pop)
  );

  // descriptor sequencer with registered output
  usb_tp_back #(
    .MAX_RESULTS (MAX_RESULTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .desc_o      (desc)
  );

  assign packet_pid_o            = desc.pid;
  assign packet_length_o         = desc.length;
  assign data_toggle_o           = desc.toggle;
  assign target_endpoint_o       = desc.endpoint;
  assign target_address_o        = desc.address;
  assign low_speed_flag_o        = desc.low_speed;
  assign interrupt_on_complete_o = desc.ioc;
  assign short_packet_detect_o   = desc.spd;
  assign byte_offset_o           = desc.offset;
  assign last_o                  = desc.last;
  assign next_toggle_o           = desc.next_toggle;
  assign truncated_o             = desc.truncated;

  // run status flags only on the closing beat
  `USB_TP_ASSERT_NOW(a_flags_on_last, out_valid_o && !last_o, !next_toggle_o && !truncated_o, "run flags on non-last beat")

  // closing beat hands back the inverted toggle
  `USB_TP_ASSERT_NOW(a_next_toggle, out_valid_o && last_o, next_toggle_o != data_toggle_o, "next toggle mismatch")

  // setup beats are fixed 8 bytes on endpoint 0
  `USB_TP_ASSERT_NOW(a_setup_shape, out_valid_o && packet_pid_o == PID_SETUP, packet_length_o == 10'd8 && target_endpoint_o == 4'd0 && byte_offset_o == 16'd0, "malformed setup beat")

  // within a run the sequencer refills the output without a gap
  `USB_TP_ASSERT_NEXT(a_run_no_gap, out_valid_o && out_ready_i && !last_o, out_valid_o, "gap inside a descriptor run")

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for usb_transfer_packetizer: a table of directed
// requests, then random ones, expanded by a local splitter model or typed in,
// and compared beat by beat with the descriptor channel under random stalls
// ----------------------------------------------------------------------------
module tb;
  import usb_tp_pkg::*;

  localparam int         MAX_RUN     = 64;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         ITEM_TARGET = 300;
  localparam int         CALM_TAIL   = 40;       // final requests run without idling
  localparam int         LONG_HOLD   = 200;      // receiver hold-off, cycles
  localparam int         DRAIN       = 40;       // quiet cycles after the last beat
  localparam int         LIMIT       = 1500000;  // cycle budget before timeout

  // one transfer request as seen on the request channel
  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] length;
    logic [9:0]  mps;
    logic        dir_in;
    logic        toggle;
    logic [6:0]  address;
    logic [3:0]  endpoint;
    logic        low_speed;
  } xfer_req_t;

  // table row; typed_n < 0 means the local model supplies the expected run
  typedef struct {
    xfer_req_t req;
    int        typed_n;
    desc_t     typed;
  } stim_row_t;

  logic        clk_i                   = 1'b0;
  logic        rst_ni                  = 1'b0;
  logic        in_valid_i              = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i               = '0;
  logic [15:0] transfer_length_i       = '0;
  logic [9:0]  max_packet_i            = '0;
  logic        direction_in_i          = 1'b0;
  logic        start_toggle_i          = 1'b0;
  logic [6:0]  device_address_i        = '0;
  logic [3:0]  endpoint_number_i       = '0;
  logic        low_speed_i             = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i             = 1'b0;
  logic [1:0]  packet_pid_o;
  logic [9:0]  packet_length_o;
  logic        data_toggle_o;
  logic [3:0]  target_endpoint_o;
  logic [6:0]  target_address_o;
  logic        low_speed_flag_o;
  logic        interrupt_on_complete_o;
  logic        short_packet_detect_o;
  logic [15:0] byte_offset_o;
  logic        last_o;
  logic        next_toggle_o;
  logic        truncated_o;

  desc_t     pending_desc[$];   // descriptors still owed by the block, oldest first
  desc_t     run_q[$];          // scratch for the run being expanded
  bit        run_cut;
  stim_row_t offered_rows[$];   // rows on the request channel, in order

  int  error_count = 0;
  int  desc_count  = 0;
  int  cut_runs    = 0;
  int  hold_count  = 0;
  int  cycle_count = 0;
  int  kind_count[4];
  bit  idle_on      = 1'b1;
  bit  hold_pending = 1'b0;

  usb_transfer_packetizer #(.MAX_RESULTS(MAX_RUN)) i_dut (.*);

  always #2 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // local model of the splitter
  // --------------------------------------------------------------------------

  // append one descriptor unless the run is already full
  function automatic void add_desc(input xfer_req_t r, input pid_e pid,
                                   input logic [9:0] len, input logic tog,
                                   input logic [3:0] ep, input logic ioc,
                                   input logic spd, input logic [15:0] off);
    desc_t d;
    d = '0;
    if (run_q.size() >= MAX_RUN) begin
      run_cut = 1'b1;
    end else begin
      d.pid       = pid;
      d.length    = len;
      d.toggle    = tog;
      d.endpoint  = ep;
      d.address   = r.address;
      d.low_speed = r.low_speed;
      d.ioc       = ioc;
      d.spd       = spd;
      d.offset    = off;
      run_q.push_back(d);
    end
  endfunction

  // chop len bytes into mps-sized packets, toggling as we go
  function automatic void add_chunks(input xfer_req_t r, input pid_e pid,
                                     input int unsigned len, input int unsigned mps,
                                     input logic tog, input logic [3:0] ep,
                                     input logic ioc_at_end);
    int unsigned rem;
    int unsigned off;
    int unsigned chunk;
    rem = len;
    off = 0;
    while (rem > 0 && !run_cut) begin
      chunk = (rem > mps) ? mps : rem;
      add_desc(r, pid, chunk[9:0], tog, ep, ioc_at_end && (rem <= mps), 1'b0, off[15:0]);
      off += chunk;
      rem -= chunk;
      tog = ~tog;
    end
  endfunction

  // expand one accepted request and queue its descriptors
  function automatic void expand_transfer(input xfer_req_t r);
    pid_e        data_pid;
    int unsigned mps;
    int unsigned len;
    desc_t       tail;
    run_q.delete();
    run_cut  = 1'b0;
    data_pid = r.dir_in ? PID_IN : PID_OUT;
    mps      = 32'(r.mps);
    len      = 32'(r.length);
    case (r.command)
      CMD_CONTROL: begin
        if (mps == 0) mps = 32'(MPS_DEF_SHORT);
        add_desc(r, PID_SETUP, SETUP_LEN, 1'b0, 4'd0, 1'b0, 1'b0, 16'd0);
        add_chunks(r, data_pid, len, mps, 1'b1, 4'd0, 1'b0);
        // status stage runs the other way, zero length, DATA1
        add_desc(r, r.dir_in ? PID_OUT : PID_IN, 10'd0, 1'b1, 4'd0, 1'b1, 1'b0, 16'd0);
      end
      CMD_BULK: begin
        if (mps == 0) mps = 32'(MPS_DEF_BULK);
        add_chunks(r, data_pid, len, mps, r.toggle, r.endpoint, 1'b1);
      end
      CMD_INTR: begin
        if (mps == 0) mps = 32'(MPS_DEF_SHORT);
        if (len > mps) len = mps;
        add_desc(r, PID_IN, len[9:0], r.toggle, r.endpoint, 1'b1, 1'b1, 16'd0);
      end
      default: begin
        // unused command code: nothing comes out
      end
    endcase
    if (run_q.size() > 0) begin
      tail             = run_q.pop_back();
      tail.last        = 1'b1;
      tail.next_toggle = ~tail.toggle;
      tail.truncated   = run_cut;
      run_q.push_back(tail);
    end
    foreach (run_q[i]) pending_desc.push_back(run_q[i]);
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  function automatic xfer_req_t mk_req(input logic [1:0] cmd, input logic [15:0] len,
                                       input logic [9:0] mps, input logic dir,
                                       input logic tog, input logic [6:0] addr,
                                       input logic [3:0] ep, input logic ls);
    xfer_req_t r;
    r.command   = cmd;
    r.length    = len;
    r.mps       = mps;
    r.dir_in    = dir;
    r.toggle    = tog;
    r.address   = addr;
    r.endpoint  = ep;
    r.low_speed = ls;
    return r;
  endfunction

  // descriptor typed in for rows whose outcome is obvious
  function automatic desc_t mk_desc(input pid_e pid, input logic [9:0] len,
                                    input logic tog, input logic [3:0] ep,
                                    input logic [6:0] addr, input logic ls,
                                    input logic ioc, input logic spd,
                                    input logic [15:0] off, input logic fin,
                                    input logic nt, input logic tr);
    desc_t d;
    d.pid         = pid;
    d.length      = len;
    d.toggle      = tog;
    d.endpoint    = ep;
    d.address     = addr;
    d.low_speed   = ls;
    d.ioc         = ioc;
    d.spd         = spd;
    d.offset      = off;
    d.last        = fin;
    d.next_toggle = nt;
    d.truncated   = tr;
    return d;
  endfunction

  // random request, weighted toward short runs with the odd huge one
  function automatic xfer_req_t rand_req();
    xfer_req_t   r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35)      r.command = CMD_CONTROL;
    else if (pick < 70) r.command = CMD_BULK;
    else if (pick < 95) r.command = CMD_INTR;
    else                r.command = CMD_UNUSED;
    pick = $urandom_range(0, 9);
    if (pick == 0)      r.mps = '0;
    else if (pick <= 5) r.mps = 10'($urandom_range(1, 64));
    else if (pick <= 7) r.mps = 10'($urandom_range(65, 1023));
    else if (pick == 8) r.mps = 10'd1023;
    else                r.mps = 10'($urandom_range(1, 4));
    pick = $urandom_range(0, 9);
    if (pick == 0)      r.length = '0;
    else if (pick <= 6) r.length = 16'($urandom_range(1, 256));
    else if (pick <= 8) r.length = 16'($urandom_range(0, 4096));
    else                r.length = 16'($urandom_range(0, 65535));
    r.dir_in    = 1'($urandom_range(0, 1));
    r.toggle    = 1'($urandom_range(0, 1));
    r.address   = 7'($urandom_range(0, 127));
    r.endpoint  = 4'($urandom_range(0, 15));
    r.low_speed = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // put one request on the channel and hold it until the beat is taken
  task automatic offer(input stim_row_t row);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    offered_rows.push_back(row);
    in_valid_i        <= 1'b1;
    command_i         <= row.req.command;
    transfer_length_i <= row.req.length;
    max_packet_i      <= row.req.mps;
    direction_in_i    <= row.req.dir_in;
    start_toggle_i    <= row.req.toggle;
    device_address_i  <= row.req.address;
    endpoint_number_i <= row.req.endpoint;
    low_speed_i       <= row.req.low_speed;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("descriptor %0d %s got 0x%0h want 0x%0h",
                                desc_count, name, got, want));
  endtask

  // both channels are sampled at the rising edge, before the block's
  // registers move; inputs only change on the falling edge
  always @(posedge clk_i) begin
    stim_row_t row;
    xfer_req_t req;
    desc_t     want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        req = mk_req(command_i, transfer_length_i, max_packet_i, direction_in_i,
                     start_toggle_i, device_address_i, endpoint_number_i, low_speed_i);
        kind_count[req.command]++;
        row = offered_rows.pop_front();
        if (row.typed_n < 0)       expand_transfer(req);
        else if (row.typed_n == 1) pending_desc.push_back(row.typed);
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_desc.size() == 0) begin
          report_mismatch($sformatf("descriptor beat with nothing expected, pid %0d len %0d",
                                    packet_pid_o, packet_length_o));
        end else begin
          want = pending_desc.pop_front();
          check_field("pid", 16'(packet_pid_o), 16'(want.pid));
          check_field("length", 16'(packet_length_o), 16'(want.length));
          check_field("toggle", 16'(data_toggle_o), 16'(want.toggle));
          check_field("endpoint", 16'(target_endpoint_o), 16'(want.endpoint));
          check_field("address", 16'(target_address_o), 16'(want.address));
          check_field("low_speed", 16'(low_speed_flag_o), 16'(want.low_speed));
          check_field("ioc", 16'(interrupt_on_complete_o), 16'(want.ioc));
          check_field("spd", 16'(short_packet_detect_o), 16'(want.spd));
          check_field("offset", byte_offset_o, want.offset);
          check_field("last", 16'(last_o), 16'(want.last));
          check_field("next_toggle", 16'(next_toggle_o), 16'(want.next_toggle));
          check_field("truncated", 16'(truncated_o), 16'(want.truncated));
        end
        if (last_o && truncated_o) cut_runs++;
        desc_count++;
      end
    end
  end

  // timeout guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == LIMIT) begin
      $display("timeout after %0d cycles, %0d descriptors outstanding",
               cycle_count, pending_desc.size());
      $display("usb_transfer_packetizer regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // descriptor channel backpressure
  // --------------------------------------------------------------------------
  initial begin
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_pending) begin
        // long hold-off: the job queue fills and the request channel stalls
        hold_pending = 1'b0;
        hold_count++;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    stim_row_t stim_tab[$];
    stim_row_t row;
    int        taken;
    int        next_roll;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // interrupt at both extremes and with the default size clamping it
    stim_tab.push_back('{mk_req(CMD_INTR, 16'd0, 10'd0, 1'b0, 1'b0, 7'd0, 4'd0, 1'b0), 1,
      mk_desc(PID_IN, 10'd0, 1'b0, 4'd0, 7'd0, 1'b0, 1'b1, 1'b1, 16'd0, 1'b1, 1'b1, 1'b0)});
    stim_tab.push_back('{mk_req(CMD_INTR, 16'hFFFF, 10'd1023, 1'b1, 1'b1, 7'd127, 4'd15,
      1'b1), 1,
      mk_desc(PID_IN, 10'd1023, 1'b1, 4'd15, 7'd127, 1'b1, 1'b1, 1'b1, 16'd0, 1'b1, 1'b0,
              1'b0)});
    stim_tab.push_back('{mk_req(CMD_INTR, 16'd100, 10'd0, 1'b0, 1'b0, 7'd5, 4'd3, 1'b0), 1,
      mk_desc(PID_IN, 10'd8, 1'b0, 4'd3, 7'd5, 1'b0, 1'b1, 1'b1, 16'd0, 1'b1, 1'b1, 1'b0)});
    // empty bulk and the unused command code: no beats at all
    stim_tab.push_back('{mk_req(CMD_BULK, 16'd0, 10'd16, 1'b1, 1'b1, 7'd9, 4'd2, 1'b0), 0,
      desc_t'('0)});
    stim_tab.push_back('{mk_req(CMD_UNUSED, 16'd40, 10'd8, 1'b0, 1'b0, 7'd9, 4'd2, 1'b0), 0,
      desc_t'('0)});
    // control: no data stage both ways, default size, exact fit at the limit,
    // one over the limit, largest transfers
    stim_tab.push_back('{mk_req(CMD_CONTROL, 16'd0, 10'd0, 1'b1, 1'b1, 7'd1, 4'd15, 1'b0),
      -1, desc_t'('0)});
    stim_tab.push_back('{mk_req(CMD_CONTROL, 16'd0, 10'd64, 1'b0, 1'b0, 7'd2, 4'd7, 1'b1),
      -1, desc_t'('0)});
    stim_tab.push_back('{mk_req(CMD_CONTROL, 16'd20, 10'd0, 1'b1, 1'b0, 7'd3, 4'd1, 1'b0),
      -1, desc_t'('0)});
    stim_tab.push_back('{mk_req(CMD_CONTROL, 16'd64, 10'd64, 1'b0, 1'b1, 7'd4, 4'd0, 1'b1),
      -1, desc_t'('0)});
    stim_tab.push_back('{mk_req(CMD_CONTROL, 16'd62, 10'd1, 1'b1, 1'b0, 7'd5, 4'd15, 1'b0),
      -1, desc_t'('0)});
    stim_tab.push_back('{mk_req(CMD_CONTROL, 16'd63, 10'd1, 1'b0, 1'b0, 7'd6, 4'd15, 1'b0),
      -1, desc_t'('0)});
    stim_tab.push_back('{mk_req(CMD_CONTROL, 16'hFFFF, 10'd1023, 1'b1, 1'b1, 7'd127, 4'd15,
      1'b1), -1, desc_t'('0)});
    stim_tab.push_back('{mk_req(CMD_CONTROL, 16'hFFFF, 10'd1, 1'b0, 1'b0, 7'd0, 4'd8, 1'b0),
      -1, desc_t'('0)});
    // bulk: default size, exact fit at the limit, one over, largest, one-chunk edge
    stim_tab.push_back('{mk_req(CMD_BULK, 16'd1, 10'd0, 1'b0, 1'b1, 7'd10, 4'd1, 1'b0), -1,
      desc_t'('0)});
    stim_tab.push_back('{mk_req(CMD_BULK, 16'd200, 10'd0, 1'b1, 1'b0, 7'd11, 4'd2, 1'b1), -1,
      desc_t'('0)});
    stim_tab.push_back('{mk_req(CMD_BULK, 16'd64, 10'd1, 1'b0, 1'b0, 7'd12, 4'd3, 1'b0), -1,
      desc_t'('0)});
    stim_tab.push_back('{mk_req(CMD_BULK, 16'd65, 10'd1, 1'b1, 1'b1, 7'd13, 4'd4, 1'b0), -1,
      desc_t'('0)});
    stim_tab.push_back('{mk_req(CMD_BULK, 16'hFFFF, 10'd1023, 1'b1, 1'b1, 7'd127, 4'd15,
      1'b1), -1, desc_t'('0)});
    stim_tab.push_back('{mk_req(CMD_BULK, 16'd1023, 10'd1023, 1'b0, 1'b0, 7'd14, 4'd5, 1'b0),
      -1, desc_t'('0)});
    stim_tab.push_back('{mk_req(CMD_BULK, 16'd1024, 10'd1023, 1'b0, 1'b1, 7'd15, 4'd6, 1'b1),
      -1, desc_t'('0)});
    stim_tab.push_back('{mk_req(CMD_INTR, 16'd5, 10'd1023, 1'b0, 1'b1, 7'd16, 4'd9, 1'b0), -1,
      desc_t'('0)});

    foreach (stim_tab[i]) offer(stim_tab[i]);

    // random phase opens with the long hold-off while requests keep coming
    hold_pending = 1'b1;
    taken        = 0;
    next_roll    = 0;
    while (taken < ITEM_TARGET) begin
      if (taken >= next_roll) begin
        idle_on   = ($urandom_range(0, 2) != 0);
        next_roll += 50;
      end
      if (ITEM_TARGET - taken <= CALM_TAIL) idle_on = 1'b0;
      row.req     = rand_req();
      row.typed_n = -1;
      row.typed   = '0;
      offer(row);
      // requests that make no beats do not count toward the total
      if (row.req.command != CMD_UNUSED &&
          !(row.req.command == CMD_BULK && row.req.length == 0))
        taken++;
    end
    in_valid_i <= 1'b0;

    while (pending_desc.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    $display("covered %0d control, %0d bulk, %0d interrupt and %0d unused-code requests",
             kind_count[CMD_CONTROL], kind_count[CMD_BULK], kind_count[CMD_INTR],
             kind_count[CMD_UNUSED]);
    $display("checked %0d descriptors, %0d runs cut at the limit, %0d long hold-offs",
             desc_count, cut_runs, hold_count);
    if (error_count == 0) begin
      $display("usb_transfer_packetizer regression: pass");
    end else begin
      $display("%0d mismatches", error_count);
      $display("usb_transfer_packetizer regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/usb_tp_pkg.sv
rtl/core/usb_tp_front.sv
rtl/core/usb_tp_fifo.sv
rtl/core/usb_tp_back.sv
rtl/core/usb_transfer_packetizer.sv
dv/tb.sv
